// ===== src/sfrpl_pkg.sv =====
// Shared types, constants and helpers for the per-line stream find-and-replace block.
// No dependencies; every other file but sfrpl_if imports this package.
package sfrpl_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PATTERN_BYTES      = 3'd0,
    REG_PATTERN_LENGTH     = 3'd1,
    REG_REPLACEMENT_BYTES  = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3,
    REG_NEWLINE_MODE       = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic sel_new;  // current run comes from the item at the input
    logic start;    // take the item: latch its run and update match state
    logic load;     // move the next result of the run into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic run_empty;  // item at the input produces no result
    logic run_end;    // result selected now is the last of its run
  } dp_status_t;

  function automatic logic [7:0] byte_of(logic [63:0] word, logic [2:0] k);
    return word[{k, 3'b000} +: 8];
  endfunction

endpackage

// ===== src/sfrpl_if.sv =====
// Valid/ready channel interfaces: input items, result items, configuration writes.
// No dependencies.
interface sfrpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_stream;
  modport source(output valid, output text_byte, output end_of_stream, input ready);
  modport sink(input valid, input text_byte, input end_of_stream, output ready);
endinterface

interface sfrpl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  modport source(output valid, output out_byte, output run_last, input ready);
  modport sink(input valid, input out_byte, input run_last, output ready);
endinterface

interface sfrpl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/sfrpl_dp.sv =====
// Datapath: configuration registers, match state, run decode and output register.
// Depends on sfrpl_pkg.
module sfrpl_dp import sfrpl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_stream,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  input  logic        out_ready
);

  logic [63:0] pat_bytes_r;
  logic [3:0]  pat_len_r;
  logic [63:0] rep_bytes_r;
  logic [3:0]  rep_len_r;
  logic        nl_mode_r;
  logic [3:0]  match_cnt_r;
  logic        line_done_r;

  // Latched run: table bytes (pattern prefix or replacement), then maybe the literal byte
  logic [7:0]  byte_r;
  logic        run_rep_r;
  logic [3:0]  run_len_r;
  logic        run_lit_r;
  logic [3:0]  idx_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [3:0]  plen_eff;
  logic [3:0]  rlen_eff;
  logic [3:0]  mc_eff;
  logic [3:0]  mc_inc;
  logic        pat_hit;
  logic        is_nl;
  logic        cfg_hit;

  logic        dec_rep;
  logic [3:0]  dec_len;
  logic        dec_lit;
  logic [3:0]  dec_total;
  logic [3:0]  match_cnt_nxt;
  logic        line_done_nxt;

  logic        cur_rep;
  logic [3:0]  cur_len;
  logic        cur_lit;
  logic [7:0]  cur_byte;
  logic [3:0]  cur_idx;
  logic [3:0]  cur_total;
  logic [7:0]  cur_out;

  always_comb begin
    if (pat_len_r == 4'd0) begin
      plen_eff = 4'd1;
    end else if (pat_len_r > 4'(MAX_PATTERN)) begin
      plen_eff = 4'(MAX_PATTERN);
    end else begin
      plen_eff = pat_len_r;
    end
    rlen_eff = (rep_len_r > 4'(MAX_REPLACEMENT)) ? 4'(MAX_REPLACEMENT) : rep_len_r;
  end

  assign mc_eff  = (match_cnt_r >= plen_eff) ? 4'd0 : match_cnt_r;
  assign mc_inc  = mc_eff + 4'd1;
  assign pat_hit = (in_text_byte == byte_of(pat_bytes_r, mc_eff[2:0]));
  assign is_nl   = (in_text_byte == NEWLINE_BYTE);

  // Decode the item at the input into its run and next match state
  always_comb begin
    dec_rep       = 1'b0;
    dec_len       = 4'd0;
    dec_lit       = 1'b0;
    match_cnt_nxt = match_cnt_r;
    line_done_nxt = line_done_r;
    if (in_end_of_stream) begin
      // flush the pending prefix
      dec_len       = match_cnt_r;
      match_cnt_nxt = 4'd0;
      line_done_nxt = 1'b0;
    end else if (nl_mode_r) begin
      if (is_nl) begin
        dec_rep = 1'b1;
        dec_len = rlen_eff;
      end else begin
        dec_lit = 1'b1;
      end
    end else if (line_done_r) begin
      dec_lit = 1'b1;
      if (is_nl) begin
        line_done_nxt = 1'b0;
      end
    end else if (pat_hit) begin
      if (mc_inc >= plen_eff) begin
        dec_rep       = 1'b1;
        dec_len       = rlen_eff;
        match_cnt_nxt = 4'd0;
        line_done_nxt = 1'b1;
      end else begin
        match_cnt_nxt = mc_inc;
      end
    end else begin
      // mismatch: give back the matched prefix, then the byte itself
      dec_len       = mc_eff;
      dec_lit       = 1'b1;
      match_cnt_nxt = 4'd0;
    end
  end

  assign dec_total = dec_len + {3'b000, dec_lit};

  assign cur_rep   = cmd.sel_new ? dec_rep      : run_rep_r;
  assign cur_len   = cmd.sel_new ? dec_len      : run_len_r;
  assign cur_lit   = cmd.sel_new ? dec_lit      : run_lit_r;
  assign cur_byte  = cmd.sel_new ? in_text_byte : byte_r;
  assign cur_idx   = cmd.sel_new ? 4'd0         : idx_r;
  assign cur_total = cur_len + {3'b000, cur_lit};
  assign cur_out   = (cur_idx < cur_len) ?
                     byte_of(cur_rep ? rep_bytes_r : pat_bytes_r, cur_idx[2:0]) : cur_byte;

  assign status.out_free  = !out_valid_r || out_ready;
  assign status.run_empty = (dec_total == 4'd0);
  assign status.run_end   = ((cur_idx + 4'd1) == cur_total);

  always_comb begin
    case (cfg_index)
      REG_PATTERN_BYTES, REG_PATTERN_LENGTH, REG_REPLACEMENT_BYTES,
      REG_REPLACEMENT_LENGTH, REG_NEWLINE_MODE: cfg_hit = 1'b1;
      default:                                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= 4'd1;
      rep_bytes_r <= '0;
      rep_len_r   <= 4'd0;
      nl_mode_r   <= 1'b0;
      match_cnt_r <= 4'd0;
      line_done_r <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_BYTES:      pat_bytes_r <= cfg_data;
          REG_PATTERN_LENGTH:     pat_len_r   <= cfg_data[3:0];
          REG_REPLACEMENT_BYTES:  rep_bytes_r <= cfg_data;
          REG_REPLACEMENT_LENGTH: rep_len_r   <= cfg_data[3:0];
          REG_NEWLINE_MODE:       nl_mode_r   <= cfg_data[0];
          default: ;
        endcase
        // drop a pending partial match
        if (cfg_hit) begin
          match_cnt_r <= 4'd0;
          line_done_r <= 1'b0;
        end
      end
      if (cmd.start) begin
        match_cnt_r <= match_cnt_nxt;
        line_done_r <= line_done_nxt;
      end
      if (cmd.load) begin
        idx_r <= cur_idx + 4'd1;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      byte_r    <= in_text_byte;
      run_rep_r <= dec_rep;
      run_len_r <= dec_len;
      run_lit_r <= dec_lit;
    end
    if (cmd.load) begin
      out_byte_r <= cur_out;
      out_last_r <= status.run_end;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

endmodule

// ===== src/sfrpl_ctrl.sv =====
// Controller: takes items and steps the datapath through each item's result run.
// Depends on sfrpl_pkg.
module sfrpl_ctrl import sfrpl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.sel_new = (state_r == ST_IDLE);
    cmd.start   = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          cmd.start = 1'b1;
          if (!status.run_empty) begin
            // first result goes straight to the output register
            cmd.load = 1'b1;
            if (!status.run_end) begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          if (status.run_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/stream_find_replace_per_line.sv =====
// Top level of the per-line stream find-and-replace block.
// Depends on sfrpl_pkg, sfrpl_if, sfrpl_ctrl and sfrpl_dp.
//
//   channel  dir  handshake            payload
//   in_ch    in   in_ch.valid/ready    text_byte[7:0], end_of_stream
//   out_ch   out  out_ch.valid/ready   out_byte[7:0], run_last
//   cfg_ch   in   cfg_ch.valid/ready   index[2:0], data[63:0]
//
// An item with zero or one result leaves the input open; one with n results holds
// the input until its last result is loaded (n up to 8: up to 7 prefix bytes plus
// the byte, or up to 8 replacement bytes), one result per cycle while out_ch.ready is high.
// rst_n (synchronous) clears match state and loads the register reset values.
// A low out_ch.ready holds the output register and, while it is full, the input.
// cfg_ch is always ready; writes are expected only while the block is idle.
module stream_find_replace_per_line import sfrpl_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  sfrpl_in_if.sink      in_ch,
  sfrpl_out_if.source   out_ch,
  sfrpl_cfg_if.sink     cfg_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  sfrpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfrpl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_text_byte     (in_ch.text_byte),
    .in_end_of_stream (in_ch.end_of_stream),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_byte         (out_ch.out_byte),
    .out_run_last     (out_ch.run_last),
    .out_ready        (out_ch.ready)
  );

`ifndef NO_ASSERTIONS
  // a result never overwrites one still waiting to be taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> status.out_free)
    else $error("result loaded while output register full");

  // an item with more than one result blocks the input next cycle
  a_busy_after_multi: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && cmd.load && !status.run_end) |=> !in_ch.ready)
    else $error("input ready during result run");

  // once the last result of a run is loaded, input opens as soon as the slot frees
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && status.run_end) |=> (in_ch.ready == status.out_free))
    else $error("input not reopened after last result");

  // a start without a load only for items that produce nothing
  a_empty_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && !cmd.load) |-> status.run_empty)
    else $error("item with results skipped");
`endif

endmodule

// ===== verif/stream_find_replace_per_line_tb.sv =====
// Testbench for stream_find_replace_per_line: directed and random text streams.
// Depends on sfrpl_pkg, the sfrpl_if channel interfaces and the block's top level.
// Results are checked in order against an in-bench rewrite predictor.
module stream_find_replace_per_line_tb;
  import sfrpl_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int TIMEOUT_UNITS = 4_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 44;
  localparam logic [2:0] UNMAPPED_REG = 3'd7;
  localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } out_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sfrpl_in_if  in_ch();
  sfrpl_out_if out_ch();
  sfrpl_cfg_if cfg_ch();

  stream_find_replace_per_line DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the match state
  logic [63:0] pat_word = '0;
  logic [3:0]  pat_len_reg = 4'd1;
  logic [63:0] rep_word = '0;
  logic [3:0]  rep_len_reg = 4'd0;
  logic        nl_mode = 1'b0;
  int unsigned match_cnt = 0;
  logic        line_done = 1'b0;

  out_item_t expected_q[$];

  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int src_max_gap = 0;
  int sink_max_gap = 0;
  bit sink_hold_req = 1'b0;

  function automatic int unsigned eff_pattern_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > MAX_PATTERN) return MAX_PATTERN;
    return pat_len_reg;
  endfunction

  function automatic void apply_reg_write(input logic [2:0] idx, input logic [63:0] value);
    case (idx)
      REG_PATTERN_BYTES:      pat_word = value;
      REG_PATTERN_LENGTH:     pat_len_reg = value[3:0];
      REG_REPLACEMENT_BYTES:  rep_word = value;
      REG_REPLACEMENT_LENGTH: rep_len_reg = value[3:0];
      REG_NEWLINE_MODE:       nl_mode = value[0];
      default:                return;
    endcase
    // any real write drops a partial match and re-arms the line
    match_cnt = 0;
    line_done = 1'b0;
  endfunction

  function automatic void predict_rewrite(input logic [7:0] b, input logic eos);
    logic [7:0] run[$];
    int unsigned plen;
    int unsigned rlen;
    plen = eff_pattern_len();
    rlen = (rep_len_reg > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len_reg;
    if (eos) begin
      for (int k = 0; k < match_cnt; k++) run.push_back(pat_word[8*k +: 8]);
      match_cnt = 0;
      line_done = 1'b0;
    end else if (nl_mode) begin
      if (b == NEWLINE_BYTE) begin
        for (int k = 0; k < rlen; k++) run.push_back(rep_word[8*k +: 8]);
      end else begin
        run.push_back(b);
      end
    end else if (line_done) begin
      run.push_back(b);
      if (b == NEWLINE_BYTE) line_done = 1'b0;
    end else begin
      if (match_cnt >= plen) match_cnt = 0;
      if (b == pat_word[8*match_cnt +: 8]) begin
        match_cnt++;
        if (match_cnt >= plen) begin
          for (int k = 0; k < rlen; k++) run.push_back(rep_word[8*k +: 8]);
          match_cnt = 0;
          line_done = 1'b1;
        end
      end else begin
        // emit the matched prefix literally, then the byte itself
        for (int k = 0; k < match_cnt; k++) run.push_back(pat_word[8*k +: 8]);
        run.push_back(b);
        match_cnt = 0;
      end
    end
    foreach (run[i]) expected_q.push_back('{data: run[i], is_last: (i == run.size() - 1)});
  endfunction

  // Predict on accepted items and writes, then check accepted results, all in one process
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg_write(cfg_ch.index, cfg_ch.data);
        reg_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_rewrite(in_ch.text_byte, in_ch.end_of_stream);
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual out_byte %h run_last %b",
                   $time, out_ch.out_byte, out_ch.run_last);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.data, out_ch.out_byte);
          end
          if (out_ch.run_last !== want.is_last) begin
            errors++;
            $display("%0t: run_last expected %b actual %b", $time, want.is_last, out_ch.run_last);
          end
        end
      end
    end
  end

  // Result receiver: random stall per item, plus a long hold-off on request
  initial begin : receiver
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      gap = $urandom_range(0, sink_max_gap);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("%0t: timed out with %0d results outstanding", $time, expected_q.size());
    $display("stream_find_replace_per_line: mismatch");
    $finish;
  end

  // Call at a clock edge; returns at the edge where the item is taken
  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come, then let the block settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Lengths carry random upper bits, which the block must drop
  task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
                           input logic [63:0] rep, input logic [3:0] rlen, input logic nl);
    drain_results();
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, {$urandom, 28'($urandom), plen});
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_REPLACEMENT_LENGTH, {$urandom, 28'($urandom), rlen});
    write_reg(REG_NEWLINE_MODE, {$urandom, 31'($urandom), nl});
  endtask

  // Default pattern is one zero byte with an empty replacement
  task automatic test_reset_values();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  // Pattern "abc" -> "XY"; byte 0 sits in the low bits
  task automatic test_pattern_match();
    configure({40'h0, "cba"}, 4'd3, {48'h0, "YX"}, 4'd2, 1'b0);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item("x", 1'b0);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item("c", 1'b0);
    send_item("a", 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // A real write drops a pending prefix; an unmapped index keeps it
  task automatic test_config_discard();
    send_item("a", 1'b0);
    drain_results();
    write_reg(REG_NEWLINE_MODE, 64'h0);
    send_item("b", 1'b0);
    send_item("a", 1'b0);
    drain_results();
    write_reg(UNMAPPED_REG, {$urandom, $urandom});
    send_item("b", 1'b0);
    send_item("c", 1'b0);
  endtask

  // Match ending on a newline still blocks the rest of the next line
  task automatic test_newline_in_pattern();
    configure({48'h0, NEWLINE_BYTE, "a"}, 4'd2, {$urandom, $urandom}, 4'd3, 1'b0);
    send_item("a", 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item("a", 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
  endtask

  task automatic test_newline_mode();
    configure({$urandom, $urandom}, 4'd1, {48'h0, "n", BACKSLASH_BYTE}, 4'd2, 1'b1);
    send_item("a", 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  // Eight results per newline while the receiver holds off: the input must stall
  task automatic test_output_stall();
    configure({$urandom, $urandom}, 4'd1, {$urandom, $urandom}, 4'd8, 1'b1);
    src_max_gap = 0;
    sink_max_gap = 0;
    sink_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_item((i % 3 == 0) ? 8'($urandom_range(0, 255)) : NEWLINE_BYTE, 1'b0);
    end
    drain_results();
  endtask

  // Mostly pattern fragments and line breaks, some noise and flushes
  task automatic send_text(input int count);
    int sent;
    int unsigned plen;
    int unsigned k;
    int r;
    sent = 0;
    plen = eff_pattern_len();
    while (sent < count) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        k = $urandom_range(1, plen);
        for (int j = 0; j < k; j++) send_item(pat_word[8*j +: 8], 1'b0);
        sent += k;
        if (k < plen || $urandom_range(0, 1)) begin
          send_item(pat_word[8*$urandom_range(0, plen - 1) +: 8], 1'b0);
          sent++;
        end
      end else if (r < 7) begin
        send_item(NEWLINE_BYTE, 1'b0);
        sent++;
      end else if (r < 9) begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
        sent++;
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
    end
  endtask

  task automatic test_random_text();
    logic [63:0] pat;
    int r;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int j = 0; j < 8; j++) begin
        r = $urandom_range(0, 3);
        pat[8*j +: 8] = (r == 0) ? 8'("a") : (r == 1) ? 8'("b") :
                        (r == 2) ? NEWLINE_BYTE : 8'($urandom_range(0, 255));
      end
      case (p)
        0: configure('1, 4'd15, {$urandom, $urandom}, 4'd15, 1'b0);
        1: configure({$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd0, 1'b0);
        2: configure(pat, 4'd8, {$urandom, $urandom}, 4'd8, 1'b1);
        3: configure('0, 4'd8, '1, 4'd1, 1'b0);
        default: configure(pat, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                           4'($urandom_range(0, 15)), ($urandom_range(0, 3) == 0));
      endcase
      // first phase runs without any idling
      src_max_gap = (p == 0) ? 0 : $urandom_range(1, 4);
      sink_max_gap = (p == 0) ? 0 : $urandom_range(1, 4);
      send_text(PHASE_ITEMS);
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.end_of_stream <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    src_max_gap = 4;
    sink_max_gap = 4;
    test_reset_values();
    test_pattern_match();
    test_config_discard();
    test_newline_in_pattern();
    test_newline_mode();
    test_output_stall();
    test_random_text();
    drain_results();

    $display("covered %0d items, %0d results and %0d register writes", items_taken,
             results_seen, reg_writes);
    $display("pattern and newline modes, length limits, flushes and long output stalls");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("stream_find_replace_per_line: match");
    end else begin
      if (expected_q.size() != 0) begin
        $display("%0t: %0d expected results, actual none", $time, expected_q.size());
      end
      $display("stream_find_replace_per_line: mismatch");
    end
    $finish;
  end

endmodule
